>>> src/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_CLEAR      = 4'd4,
    ACT_PEEK_FRONT = 4'd5,
    ACT_PEEK_BACK  = 4'd6,
    ACT_PEEK_MID   = 4'd7,
    ACT_READ       = 4'd8,
    ACT_FIND       = 4'd9
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          found;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      full;
    logic                      empty;
  } rsp_word_t;

endpackage

>>> src/dq_if.sv
interface dq_req_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::ACTION_W-1:0]         action;
  logic signed [dq_pkg::VALUE_W-1:0]   data_value;
  logic [dq_pkg::POS_W-1:0]            position;

  modport source (output valid, output action, output data_value, output position,
                  input ready);
  modport sink (input valid, input action, input data_value, input position,
                output ready);
endinterface

interface dq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [dq_pkg::VALUE_W-1:0]   result_value;
  logic [dq_pkg::POS_W-1:0]            found_position;
  logic [dq_pkg::STATUS_W-1:0]         status;
  logic [dq_pkg::COUNT_W-1:0]          item_count;
  logic                                is_full;
  logic                                is_empty;

  modport source (output valid, output result_value, output found_position,
                  output status, output item_count, output is_full, output is_empty,
                  input ready);
  modport sink (input valid, input result_value, input found_position,
                input status, input item_count, input is_full, input is_empty,
                output ready);
endinterface

>>> src/deque_ring_buffer_engine.sv
// An accepted request enters EXEC and, if it needs data, loads the memory's registered
// read port; a find reads on from the head up to the first match or the last position.
// The result then enters the output register once that is free. A new request is taken
// only after that, since one request is in flight at a time on the single read port.
// Reset (rst, synchronous): queue becomes empty, pending result dropped; the entry
// memory keeps its contents and needs no clearing pass.
module deque_ring_buffer_engine #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic              res_valid;
  logic              res_ready;
  dq_pkg::rsp_word_t res;

  logic              out_valid;
  dq_pkg::rsp_word_t out_word;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_value   = out_word.value;
  assign rsp.found_position = out_word.found;
  assign rsp.status         = out_word.status;
  assign rsp.item_count     = out_word.count;
  assign rsp.is_full        = out_word.full;
  assign rsp.is_empty       = out_word.empty;

endmodule

>>> src/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dq_ctrl.sv
module dq_ctrl #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  dq_req_if.sink                   req,
  output logic                     res_valid,
  input  logic                     res_ready,
  output dq_pkg::rsp_word_t        res,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]    ram_rdata
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = ((AW > dq_pkg::POS_W) ? AW : dq_pkg::POS_W) + 1;
  localparam int CMPW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;

  dq_pkg::ctrl_state_t state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [AW-1:0]       tail, tail_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       scan_idx, scan_idx_next;
  logic [AW-1:0]       scan_addr, scan_addr_next;

  logic [dq_pkg::ACTION_W-1:0] act;
  logic [DATA_WIDTH-1:0]       word;
  dq_pkg::status_t             status_r;
  logic                        use_data;

  dq_pkg::status_t acc_status;
  logic            acc_use;
  logic            accept;
  logic            is_empty_q;
  logic            is_full_q;
  logic            scanning;
  logic            hit;
  logic            last;
  logic            done;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == AW'(DEPTH - 1)) r = '0;
    else r = a + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) r = AW'(DEPTH - 1);
    else r = a - AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] base,
                                             input logic [SW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + off;
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign accept     = req.valid && req.ready;
  assign is_empty_q = (count == '0);
  assign is_full_q  = (count == CW'(DEPTH));

  assign scanning = (act == dq_pkg::ACT_FIND) && (status_r == dq_pkg::ST_NOTFOUND);
  assign hit      = (ram_rdata == word);
  assign last     = ((CW'(scan_idx) + CW'(1)) == count);
  assign done     = !scanning || hit || last;

  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (accept) state_next = dq_pkg::S_EXEC;
      end
      dq_pkg::S_EXEC: begin
        if (done && res_ready) state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    scan_idx_next  = scan_idx;
    scan_addr_next = scan_addr;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = DATA_WIDTH'(req.data_value);
    ram_re         = 1'b0;
    ram_raddr      = '0;
    acc_status     = dq_pkg::ST_OK;
    acc_use        = 1'b0;
    if ((state == dq_pkg::S_IDLE) && accept) begin
      scan_idx_next  = '0;
      scan_addr_next = head;
      unique case (req.action)
        dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
          if (is_full_q) begin
            acc_status = dq_pkg::ST_OVERFLOW;
          end else begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
            if (is_empty_q) begin
              head_next = '0;
              tail_next = '0;
              ram_waddr = '0;
            end else if (req.action == dq_pkg::ACT_PUSH_FRONT) begin
              head_next = addr_dec(head);
              ram_waddr = addr_dec(head);
            end else begin
              tail_next = addr_inc(tail);
              ram_waddr = addr_inc(tail);
            end
          end
        end
        dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
          if (is_empty_q) begin
            acc_status = dq_pkg::ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            acc_use   = 1'b1;
            ram_raddr = (req.action == dq_pkg::ACT_POP_FRONT) ? head : tail;
            if (count == CW'(1)) begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end else begin
              if (req.action == dq_pkg::ACT_POP_FRONT) head_next = addr_inc(head);
              else tail_next = addr_dec(tail);
              count_next = count - CW'(1);
            end
          end
        end
        dq_pkg::ACT_CLEAR: begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end
        dq_pkg::ACT_PEEK_FRONT, dq_pkg::ACT_PEEK_BACK, dq_pkg::ACT_PEEK_MID: begin
          if (is_empty_q) begin
            acc_status = dq_pkg::ST_EMPTY;
          end else begin
            ram_re  = 1'b1;
            acc_use = 1'b1;
            if (req.action == dq_pkg::ACT_PEEK_FRONT) ram_raddr = head;
            else if (req.action == dq_pkg::ACT_PEEK_BACK) ram_raddr = tail;
            else ram_raddr = addr_add(head, SW'((count - CW'(1)) >> 1));
          end
        end
        dq_pkg::ACT_READ: begin
          if (is_empty_q) begin
            acc_status = dq_pkg::ST_EMPTY;
          end else if (CMPW'(req.position) >= CMPW'(count)) begin
            acc_status = dq_pkg::ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            acc_use   = 1'b1;
            ram_raddr = addr_add(head, SW'(req.position));
          end
        end
        dq_pkg::ACT_FIND: begin
          if (is_empty_q) begin
            acc_status = dq_pkg::ST_EMPTY;
          end else begin
            acc_status = dq_pkg::ST_NOTFOUND;
            ram_re     = 1'b1;
            ram_raddr  = head;
          end
        end
        default: begin
        end
      endcase
    end else if ((state == dq_pkg::S_EXEC) && !done) begin
      scan_idx_next  = scan_idx + AW'(1);
      scan_addr_next = addr_inc(scan_addr);
      ram_re         = 1'b1;
      ram_raddr      = addr_inc(scan_addr);
    end
  end

  always_comb begin
    req.ready    = (state == dq_pkg::S_IDLE);
    res_valid    = (state == dq_pkg::S_EXEC) && done;
    res.value    = use_data ? dq_pkg::VALUE_W'($signed(ram_rdata)) : '0;
    res.found    = (scanning && hit) ? dq_pkg::POS_W'(scan_idx) : '0;
    res.status   = scanning ? (hit ? dq_pkg::ST_OK : dq_pkg::ST_NOTFOUND) : status_r;
    res.count    = dq_pkg::COUNT_W'(count);
    res.full     = is_full_q;
    res.empty    = is_empty_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    scan_addr <= scan_addr_next;
    if (accept) begin
      act      <= req.action;
      word     <= DATA_WIDTH'(req.data_value);
      status_r <= acc_status;
      use_data <= acc_use;
    end
  end

endmodule

>>> src/dq_checker.sv
module dq_checker (
  input logic      clk,
  input logic      rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  a_reset_drops: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value)
      && $stable(rsp.status) && $stable(rsp.item_count))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != dq_pkg::ST_OK) |-> (rsp.result_value == '0))
    else $error("error status with nonzero data");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.found_position != '0) |-> (rsp.status == dq_pkg::ST_OK))
    else $error("position reported without a match");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while one is in flight");

endmodule

bind deque_ring_buffer_engine dq_checker u_dq_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
